// ===== design/rcst_pkg.sv =====
// ----------------------------------------------------------------------------
// rcst_pkg: shared types and constants of the radio command stream tracker
// Character codes, the parser state enum and the queue entry type.
// ----------------------------------------------------------------------------
package rcst_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int LEN_W = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [8*4-1:0]  PFX_VFO = "vfo:";
  // transmit frequency command prefix, sixteen characters ending in ':'
  localparam logic [8*16-1:0] PFX_TX  = 128'h74785F66_72657175_656E6379_5F65783A;
  localparam logic [8*4-1:0]  PFX_TRX = "trx:";
  localparam logic [8*4-1:0]  WORD_TRUE = "true";

  // parse phases of the byte classifier
  typedef enum logic [4:0] {
    PH_PREFIX,   // matching command prefix
    PH_R_BLANK, PH_R_SIGN, PH_R_DIG,
    PH_V_BLANK, PH_V_SIGN, PH_V_DIG,
    PH_F_BLANK, PH_F_SIGN, PH_F_DIG,
    PH_TRX,      // scanning for "true"
    PH_DEAD      // rest of line ignored
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE, CMD_VFO, CMD_TX
  } cmd_t;

  // classified command handed to the execute side
  typedef struct packed {
    logic        en;        // 0: disabled byte, clear transmit frequency
    cmd_t        cmd;
    logic [1:0]  rx_sel;    // 0 A, 1 B, 2 none
    logic [31:0] freq;
    logic        talk_wr;
    logic        talk;
  } cmd_entry_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
           c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

// ===== design/rcst_if.sv =====
// ----------------------------------------------------------------------------
// rcst_if: valid/ready channel interfaces
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface rcst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       frame_end;
  modport source (output valid, byte_value, frame_end, input ready);
  modport sink (input valid, byte_value, frame_end, output ready);
endinterface

interface rcst_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] rx_a_freq;
  logic [31:0] rx_b_freq;
  logic [31:0] transmit_freq;
  logic        a_is_active;
  logic        push_to_talk;
  modport source (output valid, rx_a_freq, rx_b_freq, transmit_freq, a_is_active,
                  push_to_talk, input ready);
  modport sink (input valid, rx_a_freq, rx_b_freq, transmit_freq, a_is_active,
                push_to_talk, output ready);
endinterface

interface rcst_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/rcst_front.sv =====
// ----------------------------------------------------------------------------
// rcst_front: streaming byte classifier
// Parses command text on the fly, one byte per cycle unless the input stalls,
// and emits one entry per byte describing what the back end has to apply.
// ----------------------------------------------------------------------------
module rcst_front import rcst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       enable,
  input  logic       in_fire,
  input  logic [7:0] byte_value,
  input  logic       frame_end,
  output cmd_entry_t entry
);

  logic [LEN_W-1:0] line_length, line_length_next;
  phase_t           phase, phase_next;
  logic             ended, ended_next;        // zero byte seen
  logic             is_vfo, is_vfo_next;
  logic             is_tx, is_tx_next;
  logic             is_trx, is_trx_next;
  logic [1:0]       rmag, rmag_next;
  logic             rneg, rneg_next;
  logic [1:0]       vmag, vmag_next;
  logic             fneg, fneg_next;
  logic             fover, fover_next;
  logic [31:0]      fmag, fmag_next;
  logic             fseen, fseen_next;
  logic [2:0]       tprog, tprog_next;
  logic             tfound, tfound_next;

  logic        term;
  logic        store;
  logic [7:0]  c;
  logic [35:0] prod;
  logic [3:0]  dig;

  assign c     = byte_value;
  assign term  = c == CH_SEMI || c == CH_LF || c == CH_CR;
  assign store = !term && line_length < LEN_W'(LINE_CAPACITY - 1) && !ended;
  assign dig   = c[3:0];
  // fmag*10 + digit, saturation checked on the wide sum
  assign prod  = {1'b0, fmag, 3'b000} + {3'b000, fmag, 1'b0} + {32'd0, dig};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      phase <= PH_PREFIX;
      ended <= 1'b0;
      is_vfo <= 1'b1; is_tx <= 1'b1; is_trx <= 1'b1;
      rmag <= '0; rneg <= 1'b0; vmag <= '0;
      fneg <= 1'b0; fover <= 1'b0; fmag <= '0; fseen <= 1'b0;
      tprog <= '0; tfound <= 1'b0;
    end else if (in_fire) begin
      line_length <= line_length_next;
      phase <= phase_next;
      ended <= ended_next;
      is_vfo <= is_vfo_next; is_tx <= is_tx_next; is_trx <= is_trx_next;
      rmag <= rmag_next; rneg <= rneg_next; vmag <= vmag_next;
      fneg <= fneg_next; fover <= fover_next; fmag <= fmag_next;
      fseen <= fseen_next; tprog <= tprog_next; tfound <= tfound_next;
    end
  end

  // classify the byte and decide the entry
  always_comb begin
    line_length_next = line_length;
    phase_next = phase;
    ended_next = ended;
    is_vfo_next = is_vfo; is_tx_next = is_tx; is_trx_next = is_trx;
    rmag_next = rmag; rneg_next = rneg; vmag_next = vmag;
    fneg_next = fneg; fover_next = fover; fmag_next = fmag; fseen_next = fseen;
    tprog_next = tprog; tfound_next = tfound;

    entry.en = enable;
    entry.cmd = CMD_NONE;
    entry.rx_sel = 2'd2;
    entry.talk_wr = 1'b0;
    entry.talk = tfound;
    if (fover) entry.freq = 32'hFFFF_FFFF;
    else if (fneg) entry.freq = 32'd0 - fmag;
    else entry.freq = fmag;

    if (store) begin
      line_length_next = line_length + LEN_W'(1);
      if (c == 8'h00) begin
        ended_next = 1'b1;
      end else begin
        // prefix match on the byte position
        if (phase == PH_PREFIX) begin
          if (line_length >= LEN_W'(4) || c != PFX_VFO[8*(3-line_length[1:0]) +: 8])
            is_vfo_next = 1'b0;
          if (line_length >= LEN_W'(4) || c != PFX_TRX[8*(3-line_length[1:0]) +: 8])
            is_trx_next = 1'b0;
          if (line_length >= LEN_W'(16) ||
              c != PFX_TX[8*(15-line_length[3:0]) +: 8])
            is_tx_next = 1'b0;
          if (line_length == LEN_W'(3) && is_vfo && c == PFX_VFO[7:0])
            phase_next = PH_R_BLANK;
          else if (line_length == LEN_W'(3) && is_trx && c == PFX_TRX[7:0])
            phase_next = PH_TRX;
          else if (line_length == LEN_W'(15) && is_tx && c == PFX_TX[7:0])
            phase_next = PH_F_BLANK;
          else if (!(is_vfo_next || is_tx_next || is_trx_next))
            phase_next = PH_DEAD;
        end
        // "true" search from line start, also covers the prefix bytes
        if (c == WORD_TRUE[8*(3-tprog[1:0]) +: 8] && tprog < 3'd4)
          tprog_next = tprog + 3'd1;
        else if (c == WORD_TRUE[31:24])
          tprog_next = 3'd1;
        else
          tprog_next = 3'd0;
        if (tprog_next == 3'd4) tfound_next = 1'b1;

        case (phase)
          PH_R_BLANK, PH_R_SIGN, PH_R_DIG: begin
            if (phase == PH_R_BLANK && is_blank(c)) begin
            end else if (phase != PH_R_DIG && (c == CH_PLUS || c == CH_MINUS)
                         && phase == PH_R_BLANK) begin
              rneg_next = c == CH_MINUS;
              phase_next = PH_R_SIGN;
            end else if (is_digit(c)) begin
              if (rmag == 2'd0) rmag_next = dig > 4'd2 ? 2'd2 : dig[1:0];
              else rmag_next = 2'd2;
              phase_next = PH_R_DIG;
            end else if (phase == PH_R_DIG && c == CH_COMMA) begin
              phase_next = PH_V_BLANK;
            end else begin
              phase_next = PH_DEAD;
            end
          end
          PH_V_BLANK, PH_V_SIGN, PH_V_DIG: begin
            if (phase == PH_V_BLANK && is_blank(c)) begin
            end else if ((c == CH_PLUS || c == CH_MINUS) && phase == PH_V_BLANK) begin
              phase_next = PH_V_SIGN;
            end else if (is_digit(c)) begin
              if (vmag == 2'd0) vmag_next = dig > 4'd2 ? 2'd2 : dig[1:0];
              else vmag_next = 2'd2;
              phase_next = PH_V_DIG;
            end else if (phase == PH_V_DIG && c == CH_COMMA) begin
              phase_next = PH_F_BLANK;
            end else begin
              phase_next = PH_DEAD;
            end
          end
          PH_F_BLANK, PH_F_SIGN, PH_F_DIG: begin
            if (phase == PH_F_BLANK && is_blank(c)) begin
            end else if ((c == CH_PLUS || c == CH_MINUS) && phase == PH_F_BLANK) begin
              fneg_next = c == CH_MINUS;
              phase_next = PH_F_SIGN;
            end else if (is_digit(c)) begin
              fseen_next = 1'b1;
              if (prod[35:32] != 4'd0) begin
                fover_next = 1'b1;
                fmag_next = 32'hFFFF_FFFF;
              end else begin
                fmag_next = prod[31:0];
              end
              phase_next = PH_F_DIG;
            end else begin
              phase_next = PH_DEAD;    // number ended, value already kept
            end
          end
          default: begin
          end
        endcase
      end
    end

    // line end: hand over the parsed command
    if (term && line_length != '0) begin
      if (is_vfo && fseen && vmag == 2'd0 && phase != PH_PREFIX) begin
        entry.cmd = CMD_VFO;
        if (rmag == 2'd0) entry.rx_sel = 2'd0;
        else if (rmag == 2'd1 && !rneg) entry.rx_sel = 2'd1;
      end else if (is_tx && fseen && phase != PH_PREFIX) begin
        entry.cmd = CMD_TX;
      end else if (is_trx && (phase == PH_TRX)) begin
        entry.talk_wr = 1'b1;
      end
    end

    // reset line tracking at terminator, frame end or while disabled
    if (term || frame_end || !enable) begin
      line_length_next = '0;
      phase_next = PH_PREFIX;
      ended_next = 1'b0;
      is_vfo_next = 1'b1; is_tx_next = 1'b1; is_trx_next = 1'b1;
      rmag_next = '0; rneg_next = 1'b0; vmag_next = '0;
      fneg_next = 1'b0; fover_next = 1'b0; fmag_next = '0; fseen_next = 1'b0;
      tprog_next = '0; tfound_next = 1'b0;
    end
    if (!enable) begin
      entry.cmd = CMD_NONE;
      entry.talk_wr = 1'b0;
    end
  end

endmodule

// ===== design/rcst_queue.sv =====
// ----------------------------------------------------------------------------
// rcst_queue: two-entry command queue
// Decouples the classifier from the execute side.
// ----------------------------------------------------------------------------
module rcst_queue import rcst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output cmd_entry_t pop_data
);

  cmd_entry_t slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_data  = slot[rd_ptr];

  // write slot
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/rcst_back.sv =====
// ----------------------------------------------------------------------------
// rcst_back: command execute stage
// Applies commands to the tracked frequencies, picks the active receiver
// and holds the result register.
// ----------------------------------------------------------------------------
module rcst_back import rcst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_entry_t q_data,
  output logic       q_pop,
  rcst_result_if.source out
);

  logic [31:0] freq_a, freq_b, tx_freq;
  logic        active_a, talk;
  logic [31:0] fa_n, fb_n, tx_n, da, db;
  logic        act_n, talk_n, take;

  assign take  = !out.valid || out.ready;
  assign q_pop = q_valid && take;

  // apply command and choose receiver
  always_comb begin
    fa_n = freq_a; fb_n = freq_b; tx_n = tx_freq;
    act_n = active_a; talk_n = talk;
    if (!q_data.en) tx_n = 32'd0;
    if (q_data.cmd == CMD_VFO && q_data.rx_sel == 2'd0) fa_n = q_data.freq;
    if (q_data.cmd == CMD_VFO && q_data.rx_sel == 2'd1) fb_n = q_data.freq;
    if (q_data.cmd == CMD_TX) tx_n = q_data.freq;
    if (q_data.talk_wr) talk_n = q_data.talk;
    da = fa_n > tx_n ? fa_n - tx_n : tx_n - fa_n;
    db = fb_n > tx_n ? fb_n - tx_n : tx_n - fb_n;
    if (q_data.cmd != CMD_NONE && tx_n != 32'd0) begin
      if (fa_n != 32'd0 && fb_n == 32'd0) act_n = 1'b1;
      else if (fa_n == 32'd0 && fb_n != 32'd0) act_n = 1'b0;
      else if (fa_n != 32'd0) act_n = da <= db;
    end
  end

  // hold tracked state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_a <= '0; freq_b <= '0; tx_freq <= '0;
      active_a <= 1'b1; talk <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        freq_a <= fa_n; freq_b <= fb_n; tx_freq <= tx_n;
        active_a <= act_n; talk <= talk_n;
      end
      if (take) out.valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out.rx_a_freq <= fa_n;
      out.rx_b_freq <= fb_n;
      out.transmit_freq <= tx_n;
      out.a_is_active <= act_n;
      out.push_to_talk <= talk_n;
    end
  end

endmodule

// ===== design/radio_command_stream_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// radio_command_stream_tracker_unit: radio command stream tracker
// Tracks receiver, transmit and push-to-talk state from command text.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle and gives exactly one result, via the queue
// slot and output register. The classifier parses each byte as it arrives, so
// a whole command is decoded when its terminator comes; a two-entry queue
// feeds the execute stage, whose distance compare sets the clock path. Input
// stalls only when the queue is full. No clearing pass is needed after reset.
module radio_command_stream_tracker_unit import rcst_pkg::*; (
  input logic clk,
  input logic rst,
  rcst_cfg_if.sink      cfg,
  rcst_byte_if.sink     in,
  rcst_result_if.source out
);

  logic       enable;
  logic       q_full, q_valid, q_pop, in_fire;
  cmd_entry_t entry, q_data;

  assign cfg.ready = 1'b1;
  assign in.ready  = !q_full;
  assign in_fire   = in.valid && in.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) enable <= 1'b1;
    else if (cfg.valid) enable <= cfg.data;
  end

  rcst_front u_front (
    .clk, .rst, .enable, .in_fire,
    .byte_value(in.byte_value), .frame_end(in.frame_end), .entry
  );

  rcst_queue u_queue (
    .clk, .rst, .push(in_fire), .push_data(entry), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_data)
  );

  rcst_back u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .out
  );

endmodule
